// ===== rtl/srpg_pkg.sv =====
// Shared types, register indexes and palette ROM of the scrolling raster pixel generator.
package srpg_pkg;

   localparam int LINE_W   = 9;
   localparam int BIDX_W   = 6;
   localparam int BPL_W    = 7;
   localparam int OFS_W    = 8;
   localparam int ADDR_W   = 14;
   localparam int FRAME_W  = 16;
   localparam int REG_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   localparam logic [LINE_W:0] PULSE_LINE = 10'd21;
   localparam logic [LINE_W:0] LATCH_LINE = 10'd23;
   localparam int              QUARTER_BIT = 9;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_ZERO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_LINE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PIC_LINES    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_PAGE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_PRES  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_PRES = 3'd6;

   typedef struct packed {
      logic              color_mode;
      logic [REG_W-1:0]  scroll_zero;
      logic [BPL_W-1:0]  bytes_per_line;   // saturated
      logic [LINE_W-1:0] picture_lines;    // saturated
      logic              second_page;
      logic              scroll_present;
      logic              control_present;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic       bump_frame;
      logic       div_load;
      logic       div_sel_addr;
      logic       div_step;
      logic       latch_offset;
      logic       mul;
      logic       emit;
      logic [2:0] pix_idx;
   } cmd_type;

   typedef struct packed {
      logic is_sync;
      logic pulse_line;
      logic latch_line;
      logic in_range;
      logic four_pixels;
      logic out_free;
   } status_type;

   // {red, green, blue} for palette pal and 2-bit pixel code idx
   function automatic logic [23:0] palette_rgb(input logic [3:0] pal, input logic [1:0] idx);
      logic [23:0] c1;
      logic [23:0] c2;
      logic [23:0] c3;
      logic [23:0] res;
      case (pal)
         4'd0: begin c1 = 24'h0000FF; c2 = 24'h00FF00; c3 = 24'hFF0000; end
         4'd1: begin c1 = 24'hFFFF00; c2 = 24'hFF00FF; c3 = 24'hFF0000; end
         4'd2: begin c1 = 24'h00FFFF; c2 = 24'h0000FF; c3 = 24'hFF00FF; end
         4'd3: begin c1 = 24'h00FF00; c2 = 24'h00FFFF; c3 = 24'hFFFF00; end
         4'd4: begin c1 = 24'hFF00FF; c2 = 24'h00FFFF; c3 = 24'hFFFFFF; end
         4'd5: begin c1 = 24'hFFFFFF; c2 = 24'hFFFFFF; c3 = 24'hFFFFFF; end
         4'd6: begin c1 = 24'hC00000; c2 = 24'h8E0000; c3 = 24'hFF0000; end
         4'd7: begin c1 = 24'hC0FF00; c2 = 24'h8EFF00; c3 = 24'hFFFF00; end
         4'd8: begin c1 = 24'hC000FF; c2 = 24'h8E00FF; c3 = 24'hFF00FF; end
         4'd9: begin c1 = 24'h8EFF00; c2 = 24'h8E00FF; c3 = 24'h8E0000; end
         4'd10: begin c1 = 24'hC0FF00; c2 = 24'hC000FF; c3 = 24'hC00000; end
         4'd11: begin c1 = 24'h00FFFF; c2 = 24'hFFFF00; c3 = 24'hFF0000; end
         4'd12: begin c1 = 24'hFF0000; c2 = 24'h00FF00; c3 = 24'h00FFFF; end
         4'd13: begin c1 = 24'h00FFFF; c2 = 24'hFFFF00; c3 = 24'hFFFFFF; end
         4'd14: begin c1 = 24'hFFFF00; c2 = 24'h00FF00; c3 = 24'hFFFFFF; end
         default: begin c1 = 24'h00FFFF; c2 = 24'h00FF00; c3 = 24'hFFFFFF; end
      endcase
      case (idx)
         2'd1: res = c1;
         2'd2: res = c2;
         2'd3: res = c3;
         default: res = 24'h000000;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/srpg_ctrl.sv =====
// Sequencing state machine: decode, remainder iterations, multiply, result transfers.
module srpg_ctrl
   import srpg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_DIV    = 5'b00100,
      S_FINISH = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [2:0] pix_ff, pix_in;
   logic       last_pix;

   assign req_tready = (state_ff == S_IDLE);
   assign last_pix   = status.is_sync || (pix_ff == (status.four_pixels ? 3'd3 : 3'd7));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      pix_in   = pix_ff;
      cmd      = '0;
      cmd.pix_idx = pix_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_tvalid;
            pix_in = 3'd0;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.is_sync) begin
               cmd.bump_frame = status.pulse_line;
               if (status.latch_line) begin
                  cmd.div_load = 1'b1;
                  step_in  = 5'd31;
                  state_in = S_DIV;
               end else begin
                  state_in = S_EMIT;
               end
            end else if (!status.in_range) begin
               state_in = S_IDLE;
            end else begin
               cmd.div_load     = 1'b1;
               cmd.div_sel_addr = 1'b1;
               step_in  = 5'd9;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.latch_offset = status.is_sync;
            cmd.mul          = !status.is_sync;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               pix_in   = pix_ff + 3'd1;
               if (last_pix) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         pix_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pix_ff   <= pix_in;
      end
   end

endmodule

// ===== rtl/srpg_dpath.sv =====
// Datapath: item capture, remainder unit, address multiply, frame state and result register.
module srpg_dpath
   import srpg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   // captured item
   logic              op_ff;
   logic [LINE_W-1:0] line_ff;
   logic [BIDX_W-1:0] bidx_ff;
   logic [7:0]        vbyte_ff;
   logic [REG_W-1:0]  scroll_ff;
   logic [REG_W-1:0]  ctl_ff;

   // state
   logic [OFS_W-1:0]   offset_ff;
   logic [FRAME_W-1:0] frame_ff, frame_in;

   // remainder unit
   logic [31:0]        quo_ff, quo_in;
   logic [OFS_W-1:0]   rem_ff, rem_in;
   logic [LINE_W-1:0]  trial;
   logic [ADDR_W-1:0]  prod_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff;
   logic                  rsp_last_ff;

   logic [LINE_W:0]   lines_ext;
   logic [LINE_W:0]   line_sum;
   logic [31:0]       scroll_diff;
   logic [REG_W-1:0]  ctl;
   logic              page;
   logic              blank;
   logic [3:0]        pal;
   logic [23:0]       rgb;
   logic [ADDR_W-1:0] addr;
   logic              last_bit;
   logic [RSP_DATA_W-1:0] data_in;

   assign lines_ext = {1'b0, cfg.picture_lines};

   always_comb begin
      status.is_sync     = !op_ff;
      status.pulse_line  = ({1'b0, line_ff} == lines_ext + PULSE_LINE);
      status.latch_line  = ({1'b0, line_ff} == lines_ext + LATCH_LINE) && cfg.scroll_present;
      status.in_range    = (line_ff < cfg.picture_lines) && ({1'b0, bidx_ff} < cfg.bytes_per_line);
      status.four_pixels = cfg.color_mode;
      status.out_free    = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_tuser;
         line_ff   <= req_tdata[8:0];
         bidx_ff   <= req_tdata[14:9];
         vbyte_ff  <= req_tdata[22:15];
         scroll_ff <= req_tdata[38:23];
         ctl_ff    <= req_tdata[54:39];
      end
   end

   // restoring remainder, one dividend bit per cycle
   assign line_sum    = {1'b0, line_ff} + {2'b00, offset_ff};
   assign scroll_diff = {16'd0, scroll_ff} - {16'd0, cfg.scroll_zero};
   assign trial       = {rem_ff, quo_ff[31]};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.div_load) begin
         rem_in = '0;
         quo_in = cmd.div_sel_addr ? {line_sum, 22'd0} : scroll_diff;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (trial >= cfg.picture_lines) begin
            rem_in = OFS_W'(trial - cfg.picture_lines);
         end else begin
            rem_in = trial[OFS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.mul) begin
         prod_ff <= ADDR_W'(rem_ff) * ADDR_W'(cfg.bytes_per_line);
      end
   end

   assign frame_in = cmd.bump_frame ? frame_ff + 16'd1 : frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         frame_ff  <= '0;
      end else begin
         frame_ff <= frame_in;
         if (cmd.latch_offset) begin
            offset_ff <= rem_ff;
         end
      end
   end

   // pixel decode
   assign ctl   = cfg.control_present ? ctl_ff : 16'd0;
   assign page  = cfg.second_page & ctl[15];
   assign pal   = ctl[11:8];
   assign blank = cfg.scroll_present && !scroll_ff[QUARTER_BIT]
                  && (line_ff >= (cfg.picture_lines >> 2));
   assign addr  = prod_ff + ADDR_W'(bidx_ff);

   always_comb begin
      if (blank) begin
         rgb = 24'd0;
      end else if (cfg.color_mode) begin
         rgb = palette_rgb(pal, vbyte_ff[{cmd.pix_idx[1:0], 1'b0} +: 2]);
      end else begin
         rgb = vbyte_ff[cmd.pix_idx] ? 24'hFFFFFF : 24'h000000;
      end
      last_bit = cmd.pix_idx == (cfg.color_mode ? 3'd3 : 3'd7);
      if (status.is_sync) begin
         data_in = {frame_ff, 1'b0, 1'b0, 14'd0, 24'd0};
      end else begin
         data_in = {frame_ff, blank, page, addr, rgb[7:0], rgb[15:8], rgb[23:16]};
      end
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= data_in;
         rsp_user_ff <= status.is_sync && status.pulse_line;
         rsp_last_ff <= status.is_sync || last_bit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/scrolling_raster_pixel_generator.sv =====
// Top level: configuration registers, controller and datapath of the raster pixel generator.
//
// channel   dir  transfer when                carries
// req_*     in   req_tvalid & req_tready      one sync event or one video byte
// rsp_*     out  rsp_tvalid & rsp_tready      one pixel or sync result
// csr_*     in   csr_we                       register write, no read-back
//
// Sync item: one result; when it latches the scroll offset, 32 steps of the shared
// one-bit-per-cycle remainder unit come first. Video byte: first pixel after 10
// remainder steps and one multiply, then one pixel per cycle while rsp_tready is high;
// a byte outside the picture or outside its line is dropped.
// Reset clears the sequencer, frame counter and line offset and loads register defaults.
// rsp_tready low holds the pending pixel; the sequencer waits in place.
module scrolling_raster_pixel_generator
   import srpg_pkg::*;
#(
   parameter int MAX_LINES      = 256,
   parameter int MAX_LINE_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // line[8:0], byte_index[14:9], video_byte[22:15], scroll_value[38:23],
   // control_value[54:39], zero[55]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // red[7:0], green[15:8], blue[23:16], fetch_address[37:24], page_select[38],
   // blanked[39], frame_count[55:40]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // frame_pulse
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_wdata
);

   localparam logic [LINE_W-1:0] LINES_MAX = LINE_W'(MAX_LINES);
   localparam logic [BPL_W-1:0]  BPL_MAX   = BPL_W'(MAX_LINE_BYTES);

   logic              color_mode_ff;
   logic [REG_W-1:0]  scroll_zero_ff;
   logic [BPL_W-1:0]  bpl_ff;
   logic [LINE_W-1:0] lines_ff;
   logic              second_page_ff;
   logic              scroll_pres_ff;
   logic              control_pres_ff;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff   <= 1'b1;
         scroll_zero_ff  <= 16'd216;
         bpl_ff          <= 7'd64;
         lines_ff        <= 9'd256;
         second_page_ff  <= 1'b0;
         scroll_pres_ff  <= 1'b0;
         control_pres_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLOR_MODE:   color_mode_ff   <= csr_wdata[0];
            CSR_SCROLL_ZERO:  scroll_zero_ff  <= csr_wdata;
            CSR_BYTES_LINE:   bpl_ff          <= csr_wdata[BPL_W-1:0];
            CSR_PIC_LINES:    lines_ff        <= csr_wdata[LINE_W-1:0];
            CSR_SECOND_PAGE:  second_page_ff  <= csr_wdata[0];
            CSR_SCROLL_PRES:  scroll_pres_ff  <= csr_wdata[0];
            CSR_CONTROL_PRES: control_pres_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.color_mode      = color_mode_ff;
      cfg.scroll_zero     = scroll_zero_ff;
      cfg.second_page     = second_page_ff;
      cfg.scroll_present  = scroll_pres_ff;
      cfg.control_present = control_pres_ff;
      if (lines_ff < 9'd4) begin
         cfg.picture_lines = 9'd4;
      end else if (lines_ff > LINES_MAX) begin
         cfg.picture_lines = LINES_MAX;
      end else begin
         cfg.picture_lines = lines_ff;
      end
      if (bpl_ff < 7'd1) begin
         cfg.bytes_per_line = 7'd1;
      end else if (bpl_ff > BPL_MAX) begin
         cfg.bytes_per_line = BPL_MAX;
      end else begin
         cfg.bytes_per_line = bpl_ff;
      end
   end

   srpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srpg_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in progress");

   // frame pulse only on a single-result sync item
   a_pulse_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[39:0] == 40'd0))
      else $error("frame pulse on a pixel result");

   // blanked pixels are black
   a_blank_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39] |-> (rsp_tdata[23:0] == 24'd0))
      else $error("blanked pixel carries colour");

endmodule

// ===== verif/tb_scrolling_raster_pixel_generator.sv =====
// Self-checking testbench for the scrolling raster pixel generator: directed and random traffic.
`timescale 1ns / 100ps
module tb_scrolling_raster_pixel_generator;
   import srpg_pkg::*;

   localparam int MAX_LINES      = 256;
   localparam int MAX_LINE_BYTES = 64;
   localparam bit OP_SYNC        = 1'b0;
   localparam bit OP_BYTE        = 1'b1;
   localparam int IDLE_PCT       = 23;
   localparam int DRAIN_CYCLES   = 60;
   localparam int HOLD_CYCLES    = 400;
   localparam int STALL_LIMIT    = 5000;
   localparam int PHASE_ITEMS    = 50;

   typedef struct {
      bit        op;
      bit [8:0]  line;
      bit [5:0]  byte_index;
      bit [7:0]  video_byte;
      bit [15:0] scroll;
      bit [15:0] control;
   } raster_item_type;

   typedef struct {
      bit [7:0]  red;
      bit [7:0]  green;
      bit [7:0]  blue;
      bit [13:0] fetch_address;
      bit        page_select;
      bit        blanked;
      bit        frame_pulse;
      bit [15:0] frame_count;
      bit        last;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // line[8:0], byte_index[14:9], video_byte[22:15], scroll_value[38:23],
   // control_value[54:39], zero[55]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // op
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // red[7:0], green[15:8], blue[23:16], fetch_address[37:24], page_select[38],
   // blanked[39], frame_count[55:40]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // frame_pulse
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [REG_W-1:0]      csr_wdata = '0;

   // register copies as written, before saturation
   bit        m_colour       = 1'b1;
   bit [15:0] m_scroll_zero  = 16'd216;
   bit [6:0]  m_bytes_line   = 7'd64;
   bit [8:0]  m_pic_lines    = 9'd256;
   bit        m_second_page  = 1'b0;
   bit        m_scroll_pres  = 1'b0;
   bit        m_control_pres = 1'b0;

   bit [7:0]  line_offset = '0;
   bit [15:0] frame_total = '0;

   raster_item_type pending_items[$];
   pixel_type       expected_pixels[$];
   raster_item_type offered;

   int unsigned mismatches   = 0;
   int unsigned hold_left    = 0;
   int unsigned quiet_cycles = 0;
   bit          no_idle      = 1'b0;
   bit          hold_request = 1'b0;
   bit          hold_done    = 1'b0;

   scrolling_raster_pixel_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned active_lines();
      if (m_pic_lines < 4) return 4;
      if (m_pic_lines > MAX_LINES) return MAX_LINES;
      return m_pic_lines;
   endfunction

   function automatic int unsigned active_bytes();
      if (m_bytes_line == 0) return 1;
      if (m_bytes_line > MAX_LINE_BYTES) return MAX_LINE_BYTES;
      return m_bytes_line;
   endfunction

   function automatic void add_pending(raster_item_type it);
      pending_items.insert(pending_items.size(), it);
   endfunction

   // {r,g,b} per pixel code; code 0 is always black
   function automatic bit [23:0] palette_colour(bit [3:0] pal, bit [1:0] code);
      bit [71:0] row;   // {code 3, code 2, code 1}
      case (pal)
         4'd0:  row = {24'hFF0000, 24'h00FF00, 24'h0000FF};
         4'd1:  row = {24'hFF0000, 24'hFF00FF, 24'hFFFF00};
         4'd2:  row = {24'hFF00FF, 24'h0000FF, 24'h00FFFF};
         4'd3:  row = {24'hFFFF00, 24'h00FFFF, 24'h00FF00};
         4'd4:  row = {24'hFFFFFF, 24'h00FFFF, 24'hFF00FF};
         4'd5:  row = {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
         4'd6:  row = {24'hFF0000, 24'h8E0000, 24'hC00000};
         4'd7:  row = {24'hFFFF00, 24'h8EFF00, 24'hC0FF00};
         4'd8:  row = {24'hFF00FF, 24'h8E00FF, 24'hC000FF};
         4'd9:  row = {24'h8E0000, 24'h8E00FF, 24'h8EFF00};
         4'd10: row = {24'hC00000, 24'hC000FF, 24'hC0FF00};
         4'd11: row = {24'hFF0000, 24'hFFFF00, 24'h00FFFF};
         4'd12: row = {24'h00FFFF, 24'h00FF00, 24'hFF0000};
         4'd13: row = {24'hFFFFFF, 24'hFFFF00, 24'h00FFFF};
         4'd14: row = {24'hFFFFFF, 24'h00FF00, 24'hFFFF00};
         default: row = {24'hFFFFFF, 24'h00FF00, 24'h00FFFF};
      endcase
      if (code == 2'd0) return 24'h000000;
      return row[(int'(code) - 1) * 24 +: 24];
   endfunction

   // Works out the pixel or sync results of one accepted transfer.
   task automatic predict_pixels(raster_item_type it);
      int unsigned lines;
      int unsigned bpl;
      int unsigned count;
      int unsigned diff;
      bit [15:0]   ctl;
      bit          blank;
      bit [23:0]   rgb;
      pixel_type   px;
      lines = active_lines();
      bpl   = active_bytes();
      px.red = 0; px.green = 0; px.blue = 0;
      px.fetch_address = 0; px.page_select = 0; px.blanked = 0;
      px.frame_pulse = 0; px.last = 0;
      if (it.op == OP_SYNC) begin
         if (it.line == lines + PULSE_LINE) begin
            frame_total++;
            px.frame_pulse = 1'b1;
         end
         if (it.line == lines + LATCH_LINE && m_scroll_pres) begin
            diff = 32'(it.scroll) - 32'(m_scroll_zero);
            line_offset = 8'(diff % lines);
         end
         px.frame_count = frame_total;
         px.last = 1'b1;
         expected_pixels.insert(expected_pixels.size(), px);
         return;
      end
      if (it.line >= lines || it.byte_index >= bpl) return;
      ctl   = m_control_pres ? it.control : 16'h0000;
      blank = m_scroll_pres && !it.scroll[QUARTER_BIT] && it.line >= lines / 4;
      count = m_colour ? 4 : 8;
      px.fetch_address = 14'(((it.line + line_offset) % lines) * bpl + it.byte_index);
      px.page_select   = m_second_page & ctl[15];
      px.blanked       = blank;
      px.frame_count   = frame_total;
      for (int k = 0; k < count; k++) begin
         if (blank) rgb = 24'h000000;
         else if (m_colour) rgb = palette_colour(ctl[11:8], it.video_byte[2*k +: 2]);
         else rgb = it.video_byte[k] ? 24'hFFFFFF : 24'h000000;
         px.red   = rgb[23:16];
         px.green = rgb[15:8];
         px.blue  = rgb[7:0];
         px.last  = (k == count - 1);
         expected_pixels.insert(expected_pixels.size(), px);
      end
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_COLOR_MODE:   m_colour       = value[0];
         CSR_SCROLL_ZERO:  m_scroll_zero  = value;
         CSR_BYTES_LINE:   m_bytes_line   = value[6:0];
         CSR_PIC_LINES:    m_pic_lines    = value[8:0];
         CSR_SECOND_PAGE:  m_second_page  = value[0];
         CSR_SCROLL_PRES:  m_scroll_pres  = value[0];
         CSR_CONTROL_PRES: m_control_pres = value[0];
         default: ;
      endcase
   endtask

   task automatic set_mode(bit colour, bit [15:0] base, bit [6:0] bpl, bit [8:0] lines,
                           bit page, bit scr, bit ctl);
      write_reg(CSR_COLOR_MODE, colour);
      write_reg(CSR_SCROLL_ZERO, base);
      write_reg(CSR_BYTES_LINE, bpl);
      write_reg(CSR_PIC_LINES, lines);
      write_reg(CSR_SECOND_PAGE, page);
      write_reg(CSR_SCROLL_PRES, scr);
      write_reg(CSR_CONTROL_PRES, ctl);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sampled on the falling edge so that the driver's and monitor's updates have settled;
   // dropped bytes give no result, so the tail covers work still inside the block
   task automatic wait_idle();
      @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic raster_item_type sync_item(int unsigned line, bit [15:0] scroll);
      raster_item_type it;
      it.op = OP_SYNC;
      it.line = 9'(line);
      it.byte_index = 6'($urandom);
      it.video_byte = 8'($urandom);
      it.scroll = scroll;
      it.control = 16'($urandom);
      return it;
   endfunction

   function automatic raster_item_type byte_item(int unsigned line, int unsigned bidx,
                                                 bit [7:0] vbyte, bit [15:0] scroll,
                                                 bit [15:0] control);
      raster_item_type it;
      it.op = OP_BYTE;
      it.line = 9'(line);
      it.byte_index = 6'(bidx);
      it.video_byte = vbyte;
      it.scroll = scroll;
      it.control = control;
      return it;
   endfunction

   // mostly bytes inside the picture plus the frame and latch syncs; the rest is noise
   function automatic raster_item_type random_item();
      raster_item_type it;
      int unsigned     lines;
      int unsigned     pick;
      lines = active_lines();
      it = byte_item($urandom_range(lines - 1, 0), $urandom_range(active_bytes() - 1, 0),
                     8'($urandom), 16'($urandom), 16'($urandom));
      pick = $urandom_range(99);
      if (pick < 8) begin
         it.op = OP_SYNC;
         it.line = 9'(lines + PULSE_LINE);
      end else if (pick < 16) begin
         it.op = OP_SYNC;
         it.line = 9'(lines + LATCH_LINE);
      end else if (pick < 22) begin
         it.op = OP_SYNC;
         it.line = 9'($urandom);
      end else if (pick < 27) begin
         it.line = 9'($urandom);
      end else if (pick < 31) begin
         it.byte_index = 6'($urandom);
      end
      return it;
   endfunction

   // driver: predicts each transfer as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_pixels(offered);
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               offered = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, offered.control, offered.scroll, offered.video_byte,
                              offered.byte_index, offered.line};
               req_tuser  <= offered.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver back-pressure
   always @(posedge clock) begin : monitor
      pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("result with nothing expected: tdata=%h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("red", want.red, rsp_tdata[7:0]);
               check_field("green", want.green, rsp_tdata[15:8]);
               check_field("blue", want.blue, rsp_tdata[23:16]);
               check_field("fetch_address", want.fetch_address, rsp_tdata[37:24]);
               check_field("page_select", want.page_select, rsp_tdata[38]);
               check_field("blanked", want.blanked, rsp_tdata[39]);
               check_field("frame_count", want.frame_count, rsp_tdata[55:40]);
               check_field("frame_pulse", want.frame_pulse, rsp_tuser);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // register defaults: colour, full picture, last byte of the last line
      add_pending(byte_item(255, 63, 8'hE4, 16'h0000, 16'hFFFF));
      wait_idle();

      set_mode(1'b1, 16'd100, 7'd40, 9'd200, 1'b1, 1'b1, 1'b1);
      add_pending(sync_item(200 + PULSE_LINE, 16'h0000));
      add_pending(sync_item(200 + LATCH_LINE, 16'd107));
      for (int pal = 0; pal < 16; pal++)
         add_pending(byte_item(pal * 3, pal, 8'hE4, 16'h0200,
                               16'(((pal % 2) << 15) | (pal << 8))));
      // quarter blanking, and the last unblanked line with the quarter bit clear
      add_pending(byte_item(150, 5, 8'hFF, 16'h0000, 16'h8300));
      add_pending(byte_item(49, 39, 8'h1B, 16'h0000, 16'h0C00));
      // outside the picture and outside the line
      add_pending(byte_item(200, 0, 8'hFF, 16'h0200, 16'h0100));
      add_pending(byte_item(10, 40, 8'hFF, 16'h0200, 16'h0100));
      wait_idle();

      // mono with both sizes saturating to their minimum and a wrapping scroll difference
      set_mode(1'b0, 16'hFFFF, 7'd0, 9'd0, 1'b0, 1'b1, 1'b0);
      add_pending(sync_item(4 + PULSE_LINE, 16'hFFFF));
      add_pending(sync_item(4 + LATCH_LINE, 16'h0000));
      add_pending(byte_item(3, 0, 8'hA5, 16'h0000, 16'hFFFF));
      add_pending(byte_item(0, 0, 8'h5A, 16'hFFFF, 16'hFFFF));
      add_pending(byte_item(4, 0, 8'hFF, 16'h0200, 16'h0000));
      add_pending(byte_item(0, 1, 8'hFF, 16'h0200, 16'h0000));
      wait_idle();

      set_mode(1'b1, 16'($urandom), 7'd64, 9'd256, 1'b1, 1'b1, 1'b1);
      no_idle = 1'b1;
      repeat (PHASE_ITEMS) add_pending(random_item());
      wait_idle();
      no_idle = 1'b0;

      // receiver holds off while mono bytes keep coming
      set_mode(1'b0, 16'($urandom), 7'd1, 9'd4, 1'b1, 1'b1, 1'b1);
      repeat (PHASE_ITEMS) add_pending(random_item());
      hold_request = 1'b1;
      wait_idle();

      set_mode(1'b1, 16'($urandom), 7'($urandom_range(64, 1)), 9'($urandom_range(256, 4)),
               1'($urandom), 1'b1, 1'b1);
      repeat (PHASE_ITEMS) add_pending(random_item());
      wait_idle();

      // sizes above range saturate to the maximum; page flag without a control register
      set_mode(1'b0, 16'($urandom), 7'd127, 9'd511, 1'b1, 1'b0, 1'b0);
      repeat (PHASE_ITEMS) add_pending(random_item());
      wait_idle();

      set_mode(1'($urandom), 16'($urandom), 7'($urandom), 9'($urandom),
               1'($urandom), 1'($urandom), 1'($urandom));
      repeat (PHASE_ITEMS) add_pending(random_item());
      wait_idle();

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/srpg_pkg.sv
rtl/srpg_ctrl.sv
rtl/srpg_dpath.sv
rtl/scrolling_raster_pixel_generator.sv
verif/tb_scrolling_raster_pixel_generator.sv
